// ===== sv/gcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and constants of the GCD / LCM unit
// Field widths, the controller-to-datapath command and status words, and the
// select code for the divider's dividend and divisor.
// ----------------------------------------------------------------------------
package gcl_pkg;

    localparam int GCL_OPERAND_WIDTH = 31;
    localparam int GCL_VALUE_WIDTH   = 62;
    localparam int GCL_TAG_WIDTH     = 16;

    localparam logic GCL_OP_GCD = 1'b0;
    localparam logic GCL_OP_LCM = 1'b1;

    // Where the divider takes its dividend and divisor from when it starts.
    typedef enum logic [1:0] {
        DSRC_INPUT = 2'd0,  // operands of the word being accepted
        DSRC_PAIR  = 2'd1,  // previous divisor by the remainder just found
        DSRC_QUOT  = 2'd2   // first operand by the GCD, for the LCM
    } div_src_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_src_t div_src;
        logic     mul;
        logic     out_load;
    } gcl_cmd_t;

    typedef struct packed {
        logic b_zero;
        logic op_lcm;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } gcl_status_t;

endpackage : gcl_pkg
`default_nettype wire

// ===== sv/gcl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_if: request and response channels of the GCD / LCM unit
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface gcl_req_if #(
    parameter int OPERAND_WIDTH = gcl_pkg::GCL_OPERAND_WIDTH
);
    import gcl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;
    logic [GCL_TAG_WIDTH-1:0] request_tag;

    modport source (output valid, output operation, output operand_a,
                    output operand_b, output request_tag, input ready);
    modport sink   (input valid, input operation, input operand_a,
                    input operand_b, input request_tag, output ready);
endinterface : gcl_req_if

interface gcl_rsp_if;
    import gcl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [GCL_VALUE_WIDTH-1:0] value;
    logic                       div_zero_error;
    logic [GCL_TAG_WIDTH-1:0]   result_tag;

    modport source (output valid, output value, output div_zero_error,
                    output result_tag, input ready);
    modport sink   (input valid, input value, input div_zero_error,
                    input result_tag, output ready);
endinterface : gcl_rsp_if
`default_nettype wire

// ===== sv/gcd_lcm_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Work per word: with W = OPERAND_WIDTH and k remainder steps of Euclid's loop, a GCD
// runs k divisions, an LCM k + 1 divisions and a product, and a zero second operand
// no division. k is at most about 45 at W = 31.
// One word at a time; the shared radix-2 divider sets the pace.
// The next request word is taken as soon as the result sits in the output register.
// Reset clears the controller and the output valid; no word is in flight after it.
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// Euclid's remainder loop on a shared divider, then for the LCM the quotient
// of the first operand by the GCD times the second operand.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = gcl_pkg::GCL_OPERAND_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gcl_req_if.sink    req,
    gcl_rsp_if.source  rsp
);
    import gcl_pkg::*;

    gcl_cmd_t    cmd;
    gcl_status_t status;

    gcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gcl_dpath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (req.operation),
        .operand_a     (req.operand_a),
        .operand_b     (req.operand_b),
        .request_tag   (req.request_tag),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .value         (rsp.value),
        .div_zero_error(rsp.div_zero_error),
        .result_tag    (rsp.result_tag)
    );

endmodule : gcd_lcm_unit
`default_nettype wire

// ===== sv/gcl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_div: restoring radix-2 divider
// Produces quotient and remainder of two unsigned words, one bit per cycle.
// ----------------------------------------------------------------------------
module gcl_div #(
    parameter int OPERAND_WIDTH = gcl_pkg::GCL_OPERAND_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [OPERAND_WIDTH-1:0] dividend,
    input  wire logic [OPERAND_WIDTH-1:0] divisor,
    output logic                          busy,
    output logic                          last,
    output logic      [OPERAND_WIDTH-1:0] quotient,
    output logic      [OPERAND_WIDTH-1:0] remainder
);
    import gcl_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CW'(W);
        end
        else if (busy)
        begin
            // The partial remainder stays below the divisor, so W+1 bits suffice.
            rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], ~diff[W]};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = (cnt_reg != '0);
    assign last      = (cnt_reg == CW'(1));
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("divider started while busy");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (divisor != '0))
        else $error("divider started with a zero divisor");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("divider not running after start");

endmodule : gcl_div
`default_nettype wire

// ===== sv/gcl_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_dpath: datapath of the GCD / LCM unit
// Operand and tag registers, the shared divider, the LCM multiplier and the
// output register of the response channel.
// ----------------------------------------------------------------------------
module gcl_dpath #(
    parameter int OPERAND_WIDTH = gcl_pkg::GCL_OPERAND_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gcl_pkg::gcl_cmd_t                   cmd,
    output gcl_pkg::gcl_status_t                     status,
    input  wire logic                                operation,
    input  wire logic [OPERAND_WIDTH-1:0]            operand_a,
    input  wire logic [OPERAND_WIDTH-1:0]            operand_b,
    input  wire logic [gcl_pkg::GCL_TAG_WIDTH-1:0]   request_tag,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output logic      [gcl_pkg::GCL_VALUE_WIDTH-1:0] value,
    output logic                                     div_zero_error,
    output logic      [gcl_pkg::GCL_TAG_WIDTH-1:0]   result_tag
);
    import gcl_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;

    logic                       op_reg, op_next;
    logic                       err_reg, err_next;
    logic [W-1:0]               a0_reg, a0_next;
    logic [W-1:0]               b0_reg, b0_next;
    logic [W-1:0]               y_reg, y_next;
    logic [GCL_TAG_WIDTH-1:0]   tag_reg, tag_next;
    logic [PW-1:0]              prod_reg, prod_next;
    logic                       out_valid_reg, out_valid_next;
    logic [GCL_VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                       out_err_reg, out_err_next;
    logic [GCL_TAG_WIDTH-1:0]   out_tag_reg, out_tag_next;

    logic [W-1:0] div_dividend;
    logic [W-1:0] div_divisor;
    logic         div_busy;
    logic         div_last;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;
    logic         out_free;

    always_comb
    begin
        unique case (cmd.div_src)
            DSRC_INPUT:
            begin
                div_dividend = operand_a;
                div_divisor  = operand_b;
            end
            DSRC_PAIR:
            begin
                div_dividend = y_reg;
                div_divisor  = div_rem;
            end
            DSRC_QUOT:
            begin
                div_dividend = a0_reg;
                div_divisor  = y_reg;
            end
            default:
            begin
                div_dividend = a0_reg;
                div_divisor  = y_reg;
            end
        endcase
    end

    gcl_div #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .last     (div_last),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        op_next  = op_reg;
        err_next = err_reg;
        a0_next  = a0_reg;
        b0_next  = b0_reg;
        tag_next = tag_reg;
        y_next   = y_reg;
        if (cmd.load)
        begin
            op_next  = operation;
            err_next = (operand_b == '0);
            a0_next  = operand_a;
            b0_next  = operand_b;
            tag_next = request_tag;
            y_next   = operand_b;
        end
        else if (cmd.div_start && (cmd.div_src == DSRC_PAIR))
        begin
            // Euclid step: the remainder becomes the next divisor.
            y_next = div_rem;
        end

        // The GCD divides the first operand exactly, so (a / g) * b is the LCM.
        prod_next = cmd.mul ? PW'(div_quo) * PW'(b0_reg) : prod_reg;

        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        out_tag_next   = out_tag_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_err_next   = err_reg;
            out_tag_next   = tag_reg;
            if (err_reg)
            begin
                out_value_next = '0;
            end
            else if (op_reg == GCL_OP_LCM)
            begin
                out_value_next = GCL_VALUE_WIDTH'(prod_reg);
            end
            else
            begin
                out_value_next = GCL_VALUE_WIDTH'(y_reg);
            end
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        err_reg       <= err_next;
        a0_reg        <= a0_next;
        b0_reg        <= b0_next;
        tag_reg       <= tag_next;
        y_reg         <= y_next;
        prod_reg      <= prod_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
        out_tag_reg   <= out_tag_next;
    end

    always_comb
    begin
        status.b_zero   = (operand_b == '0);
        status.op_lcm   = (op_reg == GCL_OP_LCM);
        status.div_last = div_last;
        status.rem_zero = (div_rem == '0);
        status.out_free = out_free;
    end

    assign rsp_valid      = out_valid_reg;
    assign value          = out_value_reg;
    assign div_zero_error = out_err_reg;
    assign result_tag     = out_tag_reg;

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten before it was taken");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_value_reg == '0))
        else $error("error response carries a non-zero value");

    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> !div_busy)
        else $error("product taken while the divider is running");

endmodule : gcl_dpath
`default_nettype wire

// ===== sv/gcl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_ctrl: controller of the GCD / LCM unit
// Sequences Euclid's remainder loop, the LCM quotient and product, and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module gcl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire gcl_pkg::gcl_status_t status,
    output gcl_pkg::gcl_cmd_t         cmd
);
    import gcl_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MOD    = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_QUOT   = 6'b001000,
        ST_MUL    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_src   = DSRC_INPUT;
        cmd.mul       = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.b_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_src   = DSRC_INPUT;
                        state_next    = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (status.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (!status.rem_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DSRC_PAIR;
                    state_next    = ST_MOD;
                end
                else if (status.op_lcm)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DSRC_QUOT;
                    state_next    = ST_QUOT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_QUOT:
            begin
                if (status.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (state_reg == ST_IDLE || state_reg == ST_CHECK))
        else $error("divider started outside an issuing state");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (state_reg == ST_IDLE))
        else $error("request accepted outside the idle state");

    a_out_load_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == ST_FINISH))
        else $error("output loaded outside the finish state");

endmodule : gcl_ctrl
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the GCD / LCM unit
// Drives a table of directed words and then random words into the request
// channel, with random idle bursts on both channels, one long response stall
// and one full drain. The directed table or a behavioral Euclid predictor provides
// the expected response words, and they are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import gcl_pkg::*;

    localparam int W               = GCL_OPERAND_WIDTH;
    localparam int RANDOM_WORDS    = 480;
    localparam int QUIET_TAIL      = 60;
    localparam int HOLD_OFF_AT     = 150;
    localparam int DRAIN_AT        = 300;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 200;
    localparam int CYCLE_LIMIT     = 5_000_000;

    localparam logic [W-1:0] OPND_MAX = {W{1'b1}};
    // Consecutive Fibonacci numbers give the longest remainder chain.
    localparam logic [W-1:0] FIB_46   = 31'd1836311903;
    localparam logic [W-1:0] FIB_45   = 31'd1134903170;

    typedef struct packed {
        logic [GCL_VALUE_WIDTH-1:0] value;
        logic                       div_zero_error;
        logic [GCL_TAG_WIDTH-1:0]   result_tag;
    } gcl_result_t;

    typedef struct packed {
        logic                       operation;
        logic [W-1:0]               operand_a;
        logic [W-1:0]               operand_b;
        logic [GCL_TAG_WIDTH-1:0]   request_tag;
        logic                       typed;
        logic [GCL_VALUE_WIDTH-1:0] value;
        logic                       div_zero_error;
    } stim_row_t;

    logic clk;
    logic rst_n;

    gcl_req_if #(.OPERAND_WIDTH(W)) req_ch ();
    gcl_rsp_if                      rsp_ch ();

    gcd_lcm_unit #(
        .OPERAND_WIDTH(W)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    gcl_result_t pending_results[$];
    int          mismatch_count;
    int          cycle_count;
    bit          hold_off_req;
    bit          quiet_tail;
    stim_row_t   directed_rows[0:18];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic gcl_result_t predict_result(input logic op, input logic [W-1:0] a,
                                                   input logic [W-1:0] b,
                                                   input logic [GCL_TAG_WIDTH-1:0] tag);
        gcl_result_t res;
        bit [63:0]   x;
        bit [63:0]   y;
        bit [63:0]   r;
        bit [63:0]   product;

        res.value          = '0;
        res.div_zero_error = 1'b0;
        res.result_tag     = tag;
        if (b == '0)
        begin
            res.div_zero_error = 1'b1;
        end
        else
        begin
            x = 64'(a);
            y = 64'(b);
            do
            begin
                r = x % y;
                x = y;
                y = r;
            end
            while (r != 0);
            product = 64'(a) * 64'(b);
            if (op == GCL_OP_GCD)
                res.value = x[GCL_VALUE_WIDTH-1:0];
            else
                res.value = 62'(product / x);
        end
        return res;
    endfunction

    // Mix of word shapes: divide-by-zero, zero first operand, operands with a
    // shared factor, small operands and full-range operands.
    function automatic void pick_random_word(output logic op, output logic [W-1:0] a,
                                             output logic [W-1:0] b);
        int           kind;
        logic [W-1:0] g;

        op   = $urandom_range(0, 1) ? GCL_OP_LCM : GCL_OP_GCD;
        kind = $urandom_range(0, 99);
        g    = W'($urandom_range(1, 1 << 12));
        if (kind < 4)
        begin
            a = W'($urandom());
            b = '0;
        end
        else if (kind < 8)
        begin
            a = '0;
            b = W'($urandom());
        end
        else if (kind < 45)
        begin
            a = W'(g * $urandom_range(1, 1 << 18));
            b = W'(g * $urandom_range(1, 1 << 18));
        end
        else if (kind < 60)
        begin
            a = W'($urandom_range(1, 1000));
            b = W'($urandom_range(1, 1000));
        end
        else
        begin
            a = W'($urandom());
            b = W'($urandom());
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_word(input logic op, input logic [W-1:0] a, input logic [W-1:0] b,
                              input logic [GCL_TAG_WIDTH-1:0] tag, input gcl_result_t want);
        req_ch.operation   <= op;
        req_ch.operand_a   <= a;
        req_ch.operand_b   <= b;
        req_ch.request_tag <= tag;
        req_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        gcl_result_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word, tag", 64'(rsp_ch.result_tag), 64'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.value !== want.value)
                    report_mismatch("value", 64'(rsp_ch.value), 64'(want.value));
                if (rsp_ch.div_zero_error !== want.div_zero_error)
                    report_mismatch("div_zero_error", 64'(rsp_ch.div_zero_error),
                                    64'(want.div_zero_error));
                if (rsp_ch.result_tag !== want.result_tag)
                    report_mismatch("result_tag", 64'(rsp_ch.result_tag),
                                    64'(want.result_tag));
            end
        end
    end

    // Response side: random stall bursts in busy stretches, calm stretches
    // without stalls, and one long hold-off on request.
    initial
    begin : response_sink
        int stall_left;
        int segment_left;
        bit busy;

        stall_left   = 0;
        segment_left = 0;
        busy         = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(32, 160);
                busy         = $urandom_range(0, 2) != 0;
            end
            segment_left--;
            if (hold_off_req)
            begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (stall_left == 0 && busy && !quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timeout with %0d words outstanding", $time, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        gcl_result_t              want;
        stim_row_t                row;
        logic                     op;
        logic [W-1:0]             a;
        logic [W-1:0]             b;
        logic [GCL_TAG_WIDTH-1:0] tag;
        bit                       sender_busy;

        mismatch_count     = 0;
        hold_off_req       = 1'b0;
        quiet_tail         = 1'b0;
        sender_busy        = 1'b1;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = GCL_OP_GCD;
        req_ch.operand_a   = '0;
        req_ch.operand_b   = '0;
        req_ch.request_tag = '0;

        directed_rows = '{
            '{GCL_OP_GCD, '0,        '0,            16'h0000, 1'b1, 62'd0,        1'b1},
            '{GCL_OP_LCM, OPND_MAX,  '0,            16'hFFFF, 1'b1, 62'd0,        1'b1},
            '{GCL_OP_GCD, '0,        31'd7,         16'h0001, 1'b1, 62'd7,        1'b0},
            '{GCL_OP_LCM, '0,        31'd7,         16'h0002, 1'b1, 62'd0,        1'b0},
            '{GCL_OP_GCD, OPND_MAX,  OPND_MAX,      16'h8000, 1'b1, 62'(OPND_MAX), 1'b0},
            '{GCL_OP_LCM, OPND_MAX,  OPND_MAX,      16'h7FFF, 1'b1, 62'(OPND_MAX), 1'b0},
            '{GCL_OP_LCM, OPND_MAX,  OPND_MAX - 1,  16'h5555, 1'b0, 62'd0,        1'b0},
            '{GCL_OP_GCD, 31'd1,     31'd1,         16'hAAAA, 1'b1, 62'd1,        1'b0},
            '{GCL_OP_LCM, 31'd1,     OPND_MAX,      16'h0003, 1'b1, 62'(OPND_MAX), 1'b0},
            '{GCL_OP_GCD, 31'd12,    31'd18,        16'h0004, 1'b1, 62'd6,        1'b0},
            '{GCL_OP_LCM, 31'd12,    31'd18,        16'h0005, 1'b1, 62'd36,       1'b0},
            '{GCL_OP_GCD, FIB_46,    FIB_45,        16'h0006, 1'b1, 62'd1,        1'b0},
            '{GCL_OP_LCM, FIB_46,    FIB_45,        16'h0007, 1'b0, 62'd0,        1'b0},
            '{GCL_OP_GCD, 31'h4000_0000, 31'h0010_0000, 16'h0008, 1'b1, 62'h10_0000, 1'b0},
            '{GCL_OP_LCM, 31'h2AAA_AAAA, 31'h5555_5555, 16'h0009, 1'b0, 62'd0,    1'b0},
            '{GCL_OP_LCM, 31'd6,     OPND_MAX,      16'h000A, 1'b0, 62'd0,        1'b0},
            '{GCL_OP_GCD, OPND_MAX,  31'd1,         16'h000B, 1'b1, 62'd1,        1'b0},
            '{GCL_OP_GCD, 31'd1,     OPND_MAX,      16'h000C, 1'b1, 62'd1,        1'b0},
            '{GCL_OP_GCD, 31'd5,     '0,            16'h000D, 1'b1, 62'd0,        1'b1}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.typed)
                want = '{row.value, row.div_zero_error, row.request_tag};
            else
                want = predict_result(row.operation, row.operand_a, row.operand_b,
                                      row.request_tag);
            offer_word(row.operation, row.operand_a, row.operand_b, row.request_tag, want);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 9));
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
                sender_busy = $urandom_range(0, 2) != 0;
            if (n == RANDOM_WORDS - QUIET_TAIL)
                quiet_tail = 1'b1;
            // Stall the response side for a long stretch while words keep coming.
            if (n == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            // Let everything in flight come back before going on.
            if (n == DRAIN_AT)
            begin
                req_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            pick_random_word(op, a, b);
            tag  = GCL_TAG_WIDTH'($urandom_range(0, 65535));
            want = predict_result(op, a, b, tag);
            offer_word(op, a, b, tag, want);
            if (!quiet_tail && sender_busy && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 9));
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : tb_top
